// ===== sv/ptt_pkg.sv =====
// Shared types, codes and constants for the page table translation block.
package ptt_pkg;

  localparam int PAGE_COUNT_DEF = 256;

  localparam logic [2:0] ACT_MAP       = 3'd0;
  localparam logic [2:0] ACT_UNMAP     = 3'd1;
  localparam logic [2:0] ACT_SET_FLAG  = 3'd2;
  localparam logic [2:0] ACT_CLR_FLAG  = 3'd3;
  localparam logic [2:0] ACT_TEST_FLAG = 3'd4;
  localparam logic [2:0] ACT_TEST_PERM = 3'd5;
  localparam logic [2:0] ACT_TRANSLATE = 3'd6;

  localparam logic [1:0] FSEL_DIRTY    = 2'd0;
  localparam logic [1:0] FSEL_ACCESSED = 2'd1;
  localparam logic [1:0] FSEL_PRESENT  = 2'd2;
  localparam logic [1:0] FSEL_ALLOC    = 2'd3;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NOT_ALLOC   = 2'd1;
  localparam logic [1:0] ST_NOT_PRESENT = 2'd2;
  localparam logic [1:0] ST_PERM_DENIED = 2'd3;

  localparam logic [7:0] FLAG_ALLOC    = 8'h80;
  localparam logic [7:0] FLAG_DIRTY    = 8'h40;
  localparam logic [7:0] FLAG_ACCESSED = 8'h20;
  localparam logic [7:0] FLAG_PRESENT  = 8'h10;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] page_number;
    logic [7:0] frame_number;
    logic [3:0] permission_bits;
    logic [1:0] flag_select;
    logic [7:0] page_offset;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] physical_address;
    logic        flag_value;
    logic [15:0] entry_value;
  } out_item_t;

  typedef struct packed {
    logic [2:0] action;
    logic       in_range;
    logic [7:0] page_number;
    logic [7:0] frame_number;
    logic [3:0] perms;
    logic [7:0] fmask;
    logic       alloc_sel;
    logic [7:0] page_offset;
  } cmd_t;

endpackage

// ===== sv/ptt_front.sv =====
// Front end: accepts input transfers, classifies them and queues commands.
module ptt_front #(
  parameter int PAGE_COUNT = ptt_pkg::PAGE_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  ptt_pkg::in_item_t in_item,
  output logic              cmd_valid,
  output ptt_pkg::cmd_t     cmd,
  input  logic              cmd_pop
);
  import ptt_pkg::*;

  localparam logic [8:0] PageLimit = 9'(PAGE_COUNT);

  cmd_t       queue_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  cmd_t       cmd_in;
  logic       push_ok;
  logic       pop_ok;

  always_comb begin
    cmd_in.action       = in_item.action;
    cmd_in.in_range     = {1'b0, in_item.page_number} < PageLimit;
    cmd_in.page_number  = in_item.page_number;
    cmd_in.frame_number = in_item.frame_number;
    cmd_in.perms        = in_item.permission_bits;
    cmd_in.alloc_sel    = in_item.flag_select == FSEL_ALLOC;
    cmd_in.page_offset  = in_item.page_offset;
    case (in_item.flag_select)
      FSEL_DIRTY:    cmd_in.fmask = FLAG_DIRTY;
      FSEL_ACCESSED: cmd_in.fmask = FLAG_ACCESSED;
      FSEL_PRESENT:  cmd_in.fmask = FLAG_PRESENT;
      default:       cmd_in.fmask = FLAG_ALLOC;
    endcase
  end

  assign in_full   = count_r == 2'd2;
  assign push_ok   = in_push && !in_full;
  assign cmd_valid = count_r != 2'd0;
  assign pop_ok    = cmd_pop && cmd_valid;
  assign cmd       = queue_r[rd_ptr_r];

  assign wr_ptr_nxt = push_ok ? !wr_ptr_r : wr_ptr_r;
  assign rd_ptr_nxt = pop_ok ? !rd_ptr_r : rd_ptr_r;
  assign count_nxt  = count_r + {1'b0, push_ok} - {1'b0, pop_ok};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      queue_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

// ===== sv/ptt_back.sv =====
// Back end: page table memory, entry update and result register.
module ptt_back #(
  parameter int PAGE_COUNT = ptt_pkg::PAGE_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  ptt_pkg::cmd_t      cmd,
  output logic               cmd_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output ptt_pkg::out_item_t out_item
);
  import ptt_pkg::*;

  localparam int PageAw = $clog2(PAGE_COUNT);
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic [15:0]           page_mem [PAGE_COUNT];
  logic [PAGE_COUNT-1:0] valid_r;
  logic                  state_r, state_nxt;
  cmd_t                  cmd_r;
  logic [15:0]           rd_data_r;
  logic                  rd_valid_r;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_item_r, out_item_nxt;
  logic                  issue;
  logic                  wr_en;
  logic [PageAw-1:0]     rd_idx;
  logic [PageAw-1:0]     wr_idx;
  logic [15:0]           entry_old;
  logic [15:0]           entry_new;

  assign issue   = (state_r == ST_IDLE) && cmd_valid && (!out_valid_r || out_pop);
  assign cmd_pop = issue;
  assign rd_idx  = cmd.page_number[PageAw-1:0];
  assign wr_idx  = cmd_r.page_number[PageAw-1:0];

  always_comb begin
    case (state_r)
      ST_IDLE: state_nxt = issue ? ST_EXEC : ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    entry_old    = (cmd_r.in_range && rd_valid_r) ? rd_data_r : 16'h0000;
    entry_new    = entry_old;
    out_item_nxt = '0;
    case (cmd_r.action)
      ACT_MAP: begin
        entry_new = {cmd_r.frame_number, FLAG_ALLOC | FLAG_PRESENT | {4'h0, cmd_r.perms}};
      end
      ACT_UNMAP: begin
        entry_new = 16'h0000;
      end
      ACT_SET_FLAG: begin
        if (!cmd_r.alloc_sel) begin
          entry_new = entry_old | {8'h00, cmd_r.fmask};
        end
      end
      ACT_CLR_FLAG: begin
        if (!cmd_r.alloc_sel) begin
          entry_new = entry_old & ~{8'h00, cmd_r.fmask};
        end
      end
      ACT_TEST_FLAG: begin
        out_item_nxt.flag_value = |(entry_old[7:0] & cmd_r.fmask);
      end
      ACT_TEST_PERM: begin
        out_item_nxt.flag_value = entry_old[3:0] != cmd_r.perms;
      end
      ACT_TRANSLATE: begin
        if ((entry_old[7:0] & FLAG_ALLOC) == 8'h00) begin
          out_item_nxt.status = ST_NOT_ALLOC;
        end else if ((entry_old[7:0] & FLAG_PRESENT) == 8'h00) begin
          out_item_nxt.status = ST_NOT_PRESENT;
        end else if (entry_old[3:0] != cmd_r.perms) begin
          out_item_nxt.status = ST_PERM_DENIED;
        end else begin
          out_item_nxt.status           = ST_OK;
          out_item_nxt.physical_address = {entry_old[15:8], cmd_r.page_offset};
        end
      end
      default: begin
      end
    endcase
    out_item_nxt.entry_value = cmd_r.in_range ? entry_new : 16'h0000;
  end

  assign wr_en = (state_r == ST_EXEC) && cmd_r.in_range &&
                 ((cmd_r.action == ACT_MAP) || (cmd_r.action == ACT_UNMAP) ||
                  (cmd_r.action == ACT_SET_FLAG) || (cmd_r.action == ACT_CLR_FLAG));

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (state_r == ST_EXEC) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr_en) begin
        valid_r[wr_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      cmd_r      <= cmd;
      rd_data_r  <= page_mem[rd_idx];
      rd_valid_r <= valid_r[rd_idx];
    end
    if (wr_en) begin
      page_mem[wr_idx] <= entry_new;
    end
    if (state_r == ST_EXEC) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== sv/page_table_translate_top.sv =====
// Page table translation: front queue, table back end and result register.
// A result goes from the command queue through the table read registers to the result register.
// The back end takes a new command only after the last one has read and written its table entry.
// The two-entry command queue lets the front accept while the back end works.
// Reset is synchronous, active low; every table entry reads as zero after it,
// with no clearing pass (per-entry valid bits are cleared at once).
module page_table_translate_top #(
  parameter int PAGE_COUNT = ptt_pkg::PAGE_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  ptt_pkg::in_item_t  in_item,
  output logic               out_empty,
  input  logic               out_pop,
  output ptt_pkg::out_item_t out_item
);
  import ptt_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  ptt_front #(
    .PAGE_COUNT(PAGE_COUNT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  ptt_back #(
    .PAGE_COUNT(PAGE_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

// ===== verif/ptt_tb_pkg.sv =====
// Scoreboard for the page table translation block: shadow table and outstanding results.
package ptt_tb_pkg;
  import ptt_pkg::*;

  localparam logic [2:0] ACT_UNUSED   = 3'd7;
  localparam int         REPORT_LIMIT = 10;

  class translation_scoreboard;
    logic [15:0] shadow_entries [PAGE_COUNT_DEF];
    out_item_t   pending_results [$];
    int unsigned error_count;

    function new();
      foreach (shadow_entries[i]) shadow_entries[i] = '0;
      error_count = 0;
    endfunction

    function void flag_error(string what, logic [31:0] want, logic [31:0] got);
      error_count++;
      if (error_count <= REPORT_LIMIT)
        $display("ERROR at %0t: %s: expected %0h, got %0h", $time, what, want, got);
    endfunction

    function void note_transfer(in_item_t req);
      logic [15:0] entry;
      logic [7:0]  fmask;
      logic        in_range;
      out_item_t   res;
      in_range = int'(req.page_number) < PAGE_COUNT_DEF;
      entry = in_range ? shadow_entries[req.page_number] : '0;
      res = '0;
      case (req.flag_select)
        FSEL_DIRTY:    fmask = FLAG_DIRTY;
        FSEL_ACCESSED: fmask = FLAG_ACCESSED;
        FSEL_PRESENT:  fmask = FLAG_PRESENT;
        default:       fmask = FLAG_ALLOC;
      endcase
      case (req.action)
        ACT_MAP: begin
          entry = {req.frame_number, FLAG_ALLOC | FLAG_PRESENT | {4'b0000, req.permission_bits}};
        end
        ACT_UNMAP: begin
          entry = '0;
        end
        ACT_SET_FLAG: begin
          if (req.flag_select != FSEL_ALLOC) entry[7:0] = entry[7:0] | fmask;
        end
        ACT_CLR_FLAG: begin
          if (req.flag_select != FSEL_ALLOC) entry[7:0] = entry[7:0] & ~fmask;
        end
        ACT_TEST_FLAG: begin
          res.flag_value = |(entry[7:0] & fmask);
        end
        ACT_TEST_PERM: begin
          res.flag_value = (entry[3:0] != req.permission_bits);
        end
        ACT_TRANSLATE: begin
          if ((entry[7:0] & FLAG_ALLOC) == '0) res.status = ST_NOT_ALLOC;
          else if ((entry[7:0] & FLAG_PRESENT) == '0) res.status = ST_NOT_PRESENT;
          else if (entry[3:0] != req.permission_bits) res.status = ST_PERM_DENIED;
          else begin
            res.status = ST_OK;
            res.physical_address = {entry[15:8], req.page_offset};
          end
        end
        default: ;
      endcase
      if (in_range && req.action <= ACT_CLR_FLAG) shadow_entries[req.page_number] = entry;
      res.entry_value = in_range ? entry : '0;
      pending_results.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        flag_error("result with nothing outstanding, entry_value", '0, 32'(got.entry_value));
        return;
      end
      want = pending_results.pop_front();
      if (got.status != want.status)
        flag_error("status", 32'(want.status), 32'(got.status));
      if (got.physical_address != want.physical_address)
        flag_error("physical_address", 32'(want.physical_address),
                   32'(got.physical_address));
      if (got.flag_value != want.flag_value)
        flag_error("flag_value", 32'(want.flag_value), 32'(got.flag_value));
      if (got.entry_value != want.entry_value)
        flag_error("entry_value", 32'(want.entry_value), 32'(got.entry_value));
    endfunction
  endclass

endpackage

// ===== verif/testbench.sv =====
// Top-level testbench for the page table translation block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ptt_pkg::*;
  import ptt_tb_pkg::*;

  localparam int RANDOM_ITEMS = 450;
  localparam int IDLE_LIMIT   = 4000;

  typedef enum {POP_ALWAYS, POP_COIN, POP_EVERY_FOURTH, POP_MOSTLY} pop_mode_t;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_push = 1'b0;
  logic      in_full;
  in_item_t  in_item = '0;
  logic      out_empty;
  logic      out_pop = 1'b0;
  out_item_t out_item;

  translation_scoreboard sb;
  logic [7:0] hot_pages [8];

  page_table_translate_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic send_request(input in_item_t req);
    in_item <= req;
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
    sb.note_transfer(req);
  endtask

  task automatic issue(input logic [2:0] act, input logic [7:0] page, input logic [7:0] frame,
                       input logic [3:0] perms, input logic [1:0] fsel, input logic [7:0] offset);
    in_item_t req;
    req.action          = act;
    req.page_number     = page;
    req.frame_number    = frame;
    req.permission_bits = perms;
    req.flag_select     = fsel;
    req.page_offset     = offset;
    send_request(req);
  endtask

  task automatic idle_for(input int unsigned cycles);
    if (cycles != 0) begin
      in_push <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic hold_until_drained();
    in_push <= 1'b0;
    do @(posedge clk); while (sb.pending_results.size() != 0);
  endtask

  function automatic in_item_t random_request();
    in_item_t    req;
    int unsigned pick;
    req.frame_number    = 8'($urandom_range(0, 255));
    req.permission_bits = 4'($urandom_range(0, 15));
    req.flag_select     = 2'($urandom_range(0, 3));
    req.page_offset     = 8'($urandom_range(0, 255));
    req.page_number     = ($urandom_range(0, 9) < 8) ? hot_pages[3'($urandom_range(0, 7))]
                                                    : 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 15) req.action = ACT_MAP;
    else if (pick < 20) req.action = ACT_UNMAP;
    else if (pick < 32) req.action = ACT_SET_FLAG;
    else if (pick < 44) req.action = ACT_CLR_FLAG;
    else if (pick < 56) req.action = ACT_TEST_FLAG;
    else if (pick < 68) req.action = ACT_TEST_PERM;
    else if (pick < 98) req.action = ACT_TRANSLATE;
    else req.action = ACT_UNUSED;
    if ((req.action == ACT_TRANSLATE || req.action == ACT_TEST_PERM) && $urandom_range(0, 9) < 7)
      req.permission_bits = sb.shadow_entries[req.page_number][3:0];
    return req;
  endfunction

  initial begin
    pop_mode_t   mode;
    int unsigned phase_cycles;
    int unsigned tick;
    mode = POP_ALWAYS;
    phase_cycles = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      if (out_pop && !out_empty) sb.check_result(out_item);
      if (phase_cycles == 0) begin
        mode = pop_mode_t'($urandom_range(0, 3));
        phase_cycles = $urandom_range(20, 80);
      end
      phase_cycles--;
      tick++;
      case (mode)
        POP_ALWAYS:       out_pop <= 1'b1;
        POP_COIN:         out_pop <= ($urandom_range(0, 1) == 1);
        POP_EVERY_FOURTH: out_pop <= (tick % 4 == 0);
        default:          out_pop <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_push && !in_full) || (out_pop && !out_empty)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    in_item_t    req;
    int unsigned sent;
    int unsigned burst;
    bit          paused;
    sb = new();
    hot_pages[0] = 8'h00;
    hot_pages[1] = 8'hFF;
    for (int i = 2; i < 8; i++) hot_pages[i] = 8'($urandom_range(0, 255));
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue(ACT_TRANSLATE, 8'h00, 8'h00, 4'h0, FSEL_DIRTY, 8'h00);
    issue(ACT_TEST_FLAG, 8'h00, 8'h00, 4'h0, FSEL_ALLOC, 8'h00);
    issue(ACT_SET_FLAG, 8'h5A, 8'h00, 4'h0, FSEL_DIRTY, 8'h00);
    issue(ACT_SET_FLAG, 8'h5A, 8'h00, 4'h0, FSEL_ALLOC, 8'h00);
    issue(ACT_MAP, 8'h00, 8'hFF, 4'hF, FSEL_DIRTY, 8'h00);
    issue(ACT_TRANSLATE, 8'h00, 8'h00, 4'hF, FSEL_DIRTY, 8'hFF);
    issue(ACT_TRANSLATE, 8'h00, 8'h00, 4'h7, FSEL_DIRTY, 8'hFF);
    issue(ACT_TEST_PERM, 8'h00, 8'h00, 4'hF, FSEL_DIRTY, 8'h00);
    issue(ACT_TEST_PERM, 8'h00, 8'h00, 4'h0, FSEL_DIRTY, 8'h00);
    issue(ACT_MAP, 8'hFF, 8'h00, 4'h0, FSEL_DIRTY, 8'h00);
    issue(ACT_TRANSLATE, 8'hFF, 8'h00, 4'h0, FSEL_DIRTY, 8'h00);
    issue(ACT_TRANSLATE, 8'hFF, 8'h00, 4'h1, FSEL_DIRTY, 8'h00);
    issue(ACT_CLR_FLAG, 8'hFF, 8'h00, 4'h0, FSEL_PRESENT, 8'h00);
    issue(ACT_TRANSLATE, 8'hFF, 8'h00, 4'h0, FSEL_DIRTY, 8'h80);
    issue(ACT_TEST_FLAG, 8'hFF, 8'h00, 4'h0, FSEL_PRESENT, 8'h00);
    issue(ACT_SET_FLAG, 8'h00, 8'h00, 4'h0, FSEL_ACCESSED, 8'h00);
    issue(ACT_TEST_FLAG, 8'h00, 8'h00, 4'h0, FSEL_ACCESSED, 8'h00);
    issue(ACT_SET_FLAG, 8'h00, 8'h00, 4'h0, FSEL_DIRTY, 8'h00);
    issue(ACT_TEST_FLAG, 8'h00, 8'h00, 4'h0, FSEL_DIRTY, 8'h00);
    issue(ACT_CLR_FLAG, 8'h00, 8'h00, 4'h0, FSEL_ALLOC, 8'h00);
    issue(ACT_TEST_FLAG, 8'h00, 8'h00, 4'h0, FSEL_ALLOC, 8'h00);
    issue(ACT_SET_FLAG, 8'hFF, 8'h00, 4'h0, FSEL_PRESENT, 8'h00);
    issue(ACT_TRANSLATE, 8'hFF, 8'h00, 4'h0, FSEL_DIRTY, 8'h7F);
    issue(ACT_UNUSED, 8'h00, 8'hFF, 4'hF, FSEL_ALLOC, 8'hFF);
    issue(ACT_UNMAP, 8'h00, 8'h00, 4'h0, FSEL_DIRTY, 8'h00);
    issue(ACT_TRANSLATE, 8'h00, 8'h00, 4'hF, FSEL_DIRTY, 8'h00);
    hold_until_drained();

    sent = 0;
    paused = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 20);
      repeat (burst) begin
        req = random_request();
        send_request(req);
        if (req.action != ACT_UNUSED) sent++;
      end
      if (!paused && sent >= RANDOM_ITEMS / 2) begin
        hold_until_drained();
        paused = 1'b1;
      end else begin
        idle_for(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
      end
    end

    hold_until_drained();
    repeat (8) @(posedge clk);
    if (sb.pending_results.size() != 0)
      sb.flag_error("results still outstanding", '0, 32'(sb.pending_results.size()));
    if (sb.error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== page_table_translate_top.f =====
sv/ptt_pkg.sv
sv/ptt_front.sv
sv/ptt_back.sv
sv/page_table_translate_top.sv
verif/ptt_tb_pkg.sv
verif/testbench.sv
